FILE: rtl/stl_pkg.sv
// Shared types for the script token lexer: lexer modes and result items.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

   // Most result items one text byte can cause.
   localparam int unsigned MaxResults = 3;

   // Lexer modes, one-hot.
   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_SLASH   = 6'b000010,
      MODE_COMMENT = 6'b000100,
      MODE_QEMPTY  = 6'b001000,
      MODE_QUOTE   = 6'b010000,
      MODE_WORD    = 6'b100000
   } stl_mode_type;

   // One result item.
   typedef struct packed {
      logic       has_char;
      logic [7:0] token_char;
      logic       token_first;
      logic       token_last;
      logic       input_done;
      logic       run_last;
   } stl_res_type;

   // All result items of one text byte; entry 0 goes out first.
   typedef struct packed {
      logic [1:0]                       cnt;
      stl_res_type [MaxResults-1:0]     res;
   } stl_set_type;

endpackage

`default_nettype wire

FILE: rtl/stl_decode.sv
// Combinational lexer step: one text byte and the current mode give results and next mode.
`timescale 1ns / 1ps
`default_nettype none

module stl_decode (
   input  wire logic [7:0]            byte_val,
   input  wire stl_pkg::stl_mode_type mode,
   output stl_pkg::stl_mode_type      mode_in,
   output stl_pkg::stl_set_type       set_out
);
   import stl_pkg::*;

   localparam logic [7:0] ChSlash   = 8'h2F;
   localparam logic [7:0] ChDquote  = 8'h22;
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChLbrace  = 8'h7B;
   localparam logic [7:0] ChRbrace  = 8'h7D;
   localparam logic [7:0] ChLparen  = 8'h28;
   localparam logic [7:0] ChRparen  = 8'h29;
   localparam logic [7:0] ChSquote  = 8'h27;
   localparam logic [7:0] ChColon   = 8'h3A;
   localparam logic [7:0] ChUpperA  = 8'h41;
   localparam logic [7:0] ChUpperZ  = 8'h5A;
   localparam logic [7:0] CaseShift = 8'h20;

   logic        is_space;
   logic        is_break;
   logic        is_zero;
   logic [7:0]  low_char;

   // Outcome of the idle step: at most one result.
   logic         idle_cnt;
   stl_res_type  idle_res;
   stl_mode_type idle_mode;

   // Outcome of the word step: at most two results.
   logic [1:0]   word_cnt;
   stl_res_type  word_res0;
   stl_res_type  word_res1;
   stl_mode_type word_mode;

   logic         quote_first;
   logic [1:0]   last_idx;
   stl_set_type  set_w;

   // Byte classes.
   assign is_space = (byte_val <= ChSpace);
   assign is_zero  = (byte_val == 8'd0);
   assign is_break = (byte_val == ChLbrace) || (byte_val == ChRbrace) ||
                     (byte_val == ChLparen) || (byte_val == ChRparen) ||
                     (byte_val == ChSquote) || (byte_val == ChColon);
   assign low_char = ((byte_val >= ChUpperA) && (byte_val <= ChUpperZ)) ?
                     (byte_val + CaseShift) : byte_val;

   // Step taken between tokens.
   always_comb begin
      idle_cnt  = 1'b0;
      idle_res  = '0;
      idle_mode = MODE_IDLE;
      if (is_space) begin
         idle_mode = MODE_IDLE;
      end else if (byte_val == ChSlash) begin
         idle_mode = MODE_SLASH;
      end else if (byte_val == ChDquote) begin
         idle_mode = MODE_QEMPTY;
      end else if (is_break) begin
         idle_cnt             = 1'b1;
         idle_res.has_char    = 1'b1;
         idle_res.token_char  = byte_val;
         idle_res.token_first = 1'b1;
         idle_res.token_last  = 1'b1;
      end else begin
         idle_cnt             = 1'b1;
         idle_res.has_char    = 1'b1;
         idle_res.token_char  = low_char;
         idle_res.token_first = 1'b1;
         idle_mode            = MODE_WORD;
      end
   end

   // Step taken inside a word: whitespace or a break character ends it.
   always_comb begin
      word_cnt  = 2'd1;
      word_res0 = '0;
      word_res1 = '0;
      word_mode = MODE_IDLE;
      if (is_space) begin
         word_res0.token_last = 1'b1;
      end else if (is_break) begin
         word_cnt              = 2'd2;
         word_res0.token_last  = 1'b1;
         word_res1.has_char    = 1'b1;
         word_res1.token_char  = byte_val;
         word_res1.token_first = 1'b1;
         word_res1.token_last  = 1'b1;
      end else begin
         word_res0.has_char   = 1'b1;
         word_res0.token_char = low_char;
         word_mode            = MODE_WORD;
      end
   end

   assign quote_first = (mode == MODE_QEMPTY);

   // Mode dispatch, then the end-of-input and run markers.
   always_comb begin
      set_w    = '0;
      mode_in  = MODE_IDLE;
      last_idx = 2'd0;
      unique case (mode) inside
         MODE_SLASH: begin
            if (byte_val == ChSlash) begin
               mode_in = MODE_COMMENT;
            end else begin
               set_w.res[0].has_char    = 1'b1;
               set_w.res[0].token_char  = ChSlash;
               set_w.res[0].token_first = 1'b1;
               set_w.res[1]             = word_res0;
               set_w.res[2]             = word_res1;
               set_w.cnt                = 2'd1 + word_cnt;
               mode_in                  = word_mode;
            end
         end
         MODE_COMMENT: begin
            mode_in = ((byte_val == ChNewline) || is_zero) ? MODE_IDLE : MODE_COMMENT;
         end
         MODE_QEMPTY, MODE_QUOTE: begin
            set_w.cnt = 2'd1;
            set_w.res[0].token_first = quote_first;
            if ((byte_val == ChDquote) || is_zero) begin
               set_w.res[0].token_last = 1'b1;
               mode_in                 = MODE_IDLE;
            end else begin
               set_w.res[0].has_char   = 1'b1;
               set_w.res[0].token_char = low_char;
               mode_in                 = MODE_QUOTE;
            end
         end
         MODE_WORD: begin
            set_w.res[0] = word_res0;
            set_w.res[1] = word_res1;
            set_w.cnt    = word_cnt;
            mode_in      = word_mode;
         end
         default: begin
            set_w.res[0] = idle_res;
            set_w.cnt    = {1'b0, idle_cnt};
            mode_in      = idle_mode;
         end
      endcase

      // A zero byte always returns to idle and always yields a result.
      if (is_zero) begin
         mode_in = MODE_IDLE;
         if (set_w.cnt == 2'd0) begin
            set_w.cnt    = 2'd1;
            set_w.res[0] = '0;
         end
      end

      if (set_w.cnt != 2'd0) begin
         last_idx = set_w.cnt - 2'd1;
         set_w.res[last_idx].run_last   = 1'b1;
         set_w.res[last_idx].input_done = is_zero;
      end
   end

   assign set_out = set_w;

endmodule

`default_nettype wire

FILE: rtl/stl_rsp_buf.sv
// Result buffer: holds the result items of one byte and hands them out one a cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module stl_rsp_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire stl_pkg::stl_set_type set_in,
   output logic                      can_load,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output stl_pkg::stl_res_type      out_item
);
   import stl_pkg::*;

   logic [1:0]                   left_ff;
   logic [1:0]                   left_in;
   stl_res_type [MaxResults-1:0] ent_ff;
   stl_res_type [MaxResults-1:0] ent_in;
   logic                         take;

   assign out_valid = (left_ff != 2'd0);
   assign out_item  = ent_ff[0];
   assign take      = out_valid && !out_stall;

   // Free for a new set once the last held item leaves in this cycle.
   assign can_load = (left_ff == 2'd0) || ((left_ff == 2'd1) && take);

   // Load a fresh set, or shift the held items down as they are taken.
   always_comb begin
      left_in = left_ff;
      ent_in  = ent_ff;
      if (load && can_load) begin
         left_in = set_in.cnt;
         ent_in  = set_in.res;
      end else if (take) begin
         left_in = left_ff - 2'd1;
         ent_in  = {ent_ff[MaxResults-1], ent_ff[MaxResults-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

FILE: rtl/script_token_lexer_unit.sv
// Top level of the script token lexer: input register, mode register and result buffer.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_in_byte
//   rsp_      out        rsp_valid/rsp_stall   rsp_has_char, rsp_token_char, rsp_token_first,
//                                              rsp_token_last, rsp_input_done, rsp_run_last
//
// A byte is registered on acceptance and lexed as soon as the result buffer can take its
// results, which are then loaded into the buffer register; the first of them is on the
// result port straight from that register.
// Each result of a byte takes the output port in turn (zero to three results per byte), so
// the rate is one byte a cycle while each byte yields at most one item and rsp_stall is low.
// Reset (synchronous, active high) returns the lexer to idle and empties both registers.
// A stalled result holds the buffer, which in turn stalls the input once its register is full.
`timescale 1ns / 1ps
`default_nettype none

module script_token_lexer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_has_char,
   output logic [7:0]      rsp_token_char,
   output logic            rsp_token_first,
   output logic            rsp_token_last,
   output logic            rsp_input_done,
   output logic            rsp_run_last
);
   import stl_pkg::*;

   logic         byte_valid_ff;
   logic         byte_valid_in;
   logic [7:0]   byte_ff;
   stl_mode_type mode_ff;
   stl_mode_type mode_in;
   stl_mode_type mode_next;
   stl_set_type  set_w;
   stl_res_type  item_w;
   logic         can_load;
   logic         fire;
   logic         accept;

   // The held byte is lexed when the result buffer can take its results.
   assign fire      = byte_valid_ff && can_load;
   assign req_stall = byte_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign byte_valid_in = accept ? 1'b1 : (fire ? 1'b0 : byte_valid_ff);
   assign mode_in       = fire ? mode_next : mode_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         mode_ff       <= MODE_IDLE;
      end else begin
         byte_valid_ff <= byte_valid_in;
         mode_ff       <= mode_in;
      end
   end

   // Input byte register.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
      end
   end

   stl_decode u_decode (
      .byte_val (byte_ff),
      .mode     (mode_ff),
      .mode_in  (mode_next),
      .set_out  (set_w)
   );

   stl_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .set_in    (set_w),
      .can_load  (can_load),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (item_w)
   );

   assign rsp_has_char    = item_w.has_char;
   assign rsp_token_char  = item_w.token_char;
   assign rsp_token_first = item_w.token_first;
   assign rsp_token_last  = item_w.token_last;
   assign rsp_input_done  = item_w.input_done;
   assign rsp_run_last    = item_w.run_last;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the script token lexer: directed and random byte streams against a predictor.
`timescale 1ns / 1ps

module testbench;
   import stl_pkg::*;

   // Characters with a fixed meaning to the lexer.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] BREAKS [6] = '{8'h7B, 8'h7D, 8'h28, 8'h29, 8'h27, 8'h3A};

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned TOKEN_ITEMS = 210;

   // Tracks the lexer mode, predicts the result items of each accepted byte and checks them.
   class lexer_checker;
      stl_mode_type mode;
      stl_res_type  due[$];
      stl_res_type  batch[$];
      int unsigned  mismatches;

      function new();
         mode = MODE_IDLE;
         mismatches = 0;
      endfunction

      function bit is_break(logic [7:0] b);
         foreach (BREAKS[i]) begin
            if (b == BREAKS[i]) return 1'b1;
         end
         return 1'b0;
      endfunction

      function logic [7:0] fold_case(logic [7:0] b);
         return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
      endfunction

      function void put(logic has, logic [7:0] ch, logic first, logic last);
         stl_res_type r;
         r = '0;
         r.has_char = has;
         r.token_char = has ? ch : 8'h00;
         r.token_first = first;
         r.token_last = last;
         batch.push_back(r);
      endfunction

      // A byte seen between tokens.
      function void idle_step(logic [7:0] b);
         mode = MODE_IDLE;
         if (b > CH_SPACE) begin
            if (b == CH_SLASH) begin
               mode = MODE_SLASH;
            end else if (b == CH_QUOTE) begin
               mode = MODE_QEMPTY;
            end else if (is_break(b)) begin
               put(1'b1, b, 1'b1, 1'b1);
            end else begin
               put(1'b1, fold_case(b), 1'b1, 1'b0);
               mode = MODE_WORD;
            end
         end
      endfunction

      // A byte seen inside a word: whitespace or a break character closes it.
      function void word_step(logic [7:0] b);
         if (b <= CH_SPACE) begin
            put(1'b0, 8'h00, 1'b0, 1'b1);
            mode = MODE_IDLE;
         end else if (is_break(b)) begin
            put(1'b0, 8'h00, 1'b0, 1'b1);
            idle_step(b);
         end else begin
            put(1'b1, fold_case(b), 1'b0, 1'b0);
            mode = MODE_WORD;
         end
      endfunction

      // Queues the result items of one accepted byte; returns 1 if the byte did anything.
      function bit lex_byte(logic [7:0] b);
         stl_mode_type was;
         logic first;
         was = mode;
         batch.delete();
         case (mode) inside
            MODE_SLASH: begin
               if (b == CH_SLASH) begin
                  mode = MODE_COMMENT;
               end else begin
                  put(1'b1, CH_SLASH, 1'b1, 1'b0);
                  mode = MODE_WORD;
                  word_step(b);
               end
            end
            MODE_COMMENT: begin
               if (b == CH_NEWLINE || b == CH_NUL) mode = MODE_IDLE;
            end
            MODE_QEMPTY, MODE_QUOTE: begin
               first = (mode == MODE_QEMPTY);
               if (b == CH_QUOTE || b == CH_NUL) begin
                  put(1'b0, 8'h00, first, 1'b1);
                  mode = MODE_IDLE;
               end else begin
                  put(1'b1, fold_case(b), first, 1'b0);
                  mode = MODE_QUOTE;
               end
            end
            MODE_WORD: word_step(b);
            default: idle_step(b);
         endcase
         // The end of input always yields at least one item, the last one flagged.
         if (b == CH_NUL) begin
            mode = MODE_IDLE;
            if (batch.size() == 0) put(1'b0, 8'h00, 1'b0, 1'b0);
            batch[batch.size()-1].input_done = 1'b1;
         end
         if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
         foreach (batch[i]) due.push_back(batch[i]);
         return batch.size() != 0 || mode != was;
      endfunction

      function void report(string what, stl_res_type want, stl_res_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s: expected has=%b char=%h first=%b last=%b done=%b run=%b",
               $time, what, want.has_char, want.token_char, want.token_first,
               want.token_last, want.input_done, want.run_last);
            $display("   got has=%b char=%h first=%b last=%b done=%b run=%b",
               got.has_char, got.token_char, got.token_first, got.token_last,
               got.input_done, got.run_last);
         end
      endfunction

      function void match_result(stl_res_type got);
         stl_res_type want;
         if (due.size() == 0) begin
            report("unexpected item", '0, got);
         end else begin
            want = due.pop_front();
            if (got.has_char !== want.has_char || got.token_char !== want.token_char ||
                got.token_first !== want.token_first || got.token_last !== want.token_last ||
                got.input_done !== want.input_done || got.run_last !== want.run_last) begin
               report("item mismatch", want, got);
            end
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_has_char;
   logic [7:0]  rsp_token_char;
   logic        rsp_token_first;
   logic        rsp_token_last;
   logic        rsp_input_done;
   logic        rsp_run_last;
   stl_res_type rsp_item;

   lexer_checker sb = new();
   int unsigned  token_items = 0;
   int unsigned  cycles = 0;
   int unsigned  stall_left = 0;
   bit           quiet = 1'b0;

   script_token_lexer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_has_char    (rsp_has_char),
      .rsp_token_char  (rsp_token_char),
      .rsp_token_first (rsp_token_first),
      .rsp_token_last  (rsp_token_last),
      .rsp_input_done  (rsp_input_done),
      .rsp_run_last    (rsp_run_last)
   );

   assign rsp_item = {rsp_has_char, rsp_token_char, rsp_token_first, rsp_token_last,
                      rsp_input_done, rsp_run_last};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** script_token_lexer_unit: FAILED **");
         $finish;
      end
   end

   // Check each accepted result item, then choose the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.match_result(rsp_item);
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case ($urandom_range(0, 99)) inside
            [0:64]: rsp_stall <= 1'b0;
            [65:94]: begin
               rsp_stall <= !quiet;
               stall_left <= quiet ? 0 : $urandom_range(0, 2);
            end
            default: begin
               rsp_stall <= !quiet;
               stall_left <= quiet ? 0 : $urandom_range(6, 20);
            end
         endcase
      end
   end

   // Offers one byte after an optional gap and waits until it is taken.
   task automatic send_byte(input logic [7:0] b);
      int r;
      r = $urandom_range(0, 99);
      if (!quiet && r >= 60) begin
         req_valid <= 1'b0;
         repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 25)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.lex_byte(b));
      token_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Holds the input back until every predicted item has come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] word_char();
      return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(65, 122))
                                         : 8'($urandom_range(33, 255));
   endfunction

   initial begin
      int          kind;
      int          len;
      bit          pressed;
      logic [7:0]  c;
      pressed = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: slash inside a word, breaks, quotes, comments, held slash and the end byte.
      send_text("Zq/:");
      send_text("\"A b\"");
      send_text("\"\"");
      send_text("//x\n");
      send_text("/(");
      send_text("{})'");
      send_byte(8'hFF);
      send_byte(CH_NUL);
      send_text("\"x");
      send_byte(CH_NUL);
      send_byte(CH_SLASH);
      send_byte(CH_NUL);
      send_byte(CH_NUL);
      drain();

      // Random token streams with some noise and broken sequences.
      while (token_items < TOKEN_ITEMS) begin
         if ($urandom_range(0, 24) == 0) quiet = !quiet;
         if (!pressed && token_items >= TOKEN_ITEMS / 2) begin
            drain();
            pressed = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            len = $urandom_range(1, 6);
            repeat (len) send_byte(word_char());
            send_byte(($urandom_range(0, 3) == 0) ? BREAKS[$urandom_range(0, 5)]
                                                  : 8'($urandom_range(1, 32)));
         end else if (kind < 42) begin
            send_byte(BREAKS[$urandom_range(0, 5)]);
         end else if (kind < 58) begin
            send_byte(CH_QUOTE);
            len = $urandom_range(0, 5);
            repeat (len) begin
               c = 8'($urandom_range(1, 255));
               send_byte((c == CH_QUOTE) ? CH_SPACE : c);
            end
            if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE);
         end else if (kind < 66) begin
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            len = $urandom_range(0, 4);
            repeat (len) begin
               c = 8'($urandom_range(1, 255));
               send_byte((c == CH_NEWLINE) ? CH_SPACE : c);
            end
            send_byte(CH_NEWLINE);
         end else if (kind < 76) begin
            send_byte(CH_SLASH);
            send_byte(8'($urandom_range(0, 255)));
         end else if (kind < 82) begin
            send_byte(CH_NUL);
         end else if (kind < 90) begin
            send_byte(8'($urandom_range(1, 32)));
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end

      // Let the last items out, then watch a little longer for strays.
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** script_token_lexer_unit: PASSED **");
      end else begin
         $display("** script_token_lexer_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: script_token_lexer_unit.f
rtl/stl_pkg.sv
rtl/stl_decode.sv
rtl/stl_rsp_buf.sv
rtl/script_token_lexer_unit.sv
sim/testbench.sv
